/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the parser RTL.
// Every check samples on the rising edge of clk and is off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds on every cycle.
`define MNP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define MNP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define MNP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/mnp_pkg.sv */
// Package for the MIDI note message parser: status codes, event kinds,
// message positions and the decoded result type. No dependencies.
`timescale 1ns / 1ps

package mnp_pkg;

  localparam logic [7:0] STATUS_NOTE_ON   = 8'h90;
  localparam logic [7:0] STATUS_NOTE_OFF  = 8'h80;
  localparam logic [7:0] STATUS_CHAN_PRES = 8'hD0;
  localparam logic [7:0] STATUS_RESET     = 8'h00;

  localparam logic KIND_NOTE_ON  = 1'b0;
  localparam logic KIND_NOTE_OFF = 1'b1;

  // Message lengths, status byte included.
  localparam logic [1:0] LEN_SHORT = 2'd2;
  localparam logic [1:0] LEN_FULL  = 2'd3;

  // Byte position within the current message, status byte included.
  localparam logic [1:0] POS_NONE   = 2'd0;
  localparam logic [1:0] POS_STATUS = 2'd1;
  localparam logic [1:0] POS_FIRST  = 2'd2;

  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [6:0] note;
    logic [6:0] velocity;
  } mnp_result_t;

endpackage

/* hw/rtl/mnp_in_reg.sv */
// Input register of the MIDI note parser: holds one received word until the
// decode stage takes it. Depends on nothing but the clock and reset.
`timescale 1ns / 1ps

module mnp_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_ready,
  input  logic [7:0] rx_byte,
  input  logic       advance,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  // Refill whenever the stage is empty or is handing its word on.
  assign rx_ready = !byte_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (rx_ready) begin
      byte_valid <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_ready && rx_valid) begin
      byte_data <= rx_byte;
    end
  end

endmodule

/* hw/rtl/mnp_core.sv */
// Parser state and combinational decode of one MIDI word into a note event.
// Depends on mnp_pkg for status codes, positions and the result type.
`timescale 1ns / 1ps

module mnp_core
  import mnp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  logic [7:0]  byte_data,
  output mnp_result_t result
);

  logic [7:0] status_held, status_held_next;
  logic [1:0] message_length, message_length_next;
  logic [1:0] byte_position, byte_position_next;
  logic [6:0] first_data, first_data_next;

  logic [6:0] velocity;
  logic       complete;

  always_comb begin
    status_held_next    = status_held;
    message_length_next = message_length;
    byte_position_next  = byte_position;
    first_data_next     = first_data;
    velocity            = 7'd0;
    complete            = 1'b0;
    result              = '0;

    if (byte_data[7]) begin
      // Status word: restart the message, set length for known codes.
      if (byte_data == STATUS_NOTE_ON || byte_data == STATUS_NOTE_OFF) begin
        message_length_next = LEN_FULL;
      end else if (byte_data == STATUS_CHAN_PRES) begin
        message_length_next = LEN_SHORT;
      end
      status_held_next   = byte_data;
      byte_position_next = POS_STATUS;
    end else if (byte_position != POS_NONE) begin
      if (byte_position == POS_STATUS) begin
        first_data_next    = byte_data[6:0];
        byte_position_next = POS_FIRST;
        complete           = (message_length <= LEN_SHORT);
      end else begin
        velocity = byte_data[6:0];
        complete = 1'b1;
      end
    end

    if (complete) begin
      // Return to the first data slot so running status works.
      byte_position_next = POS_STATUS;
      if (status_held == STATUS_NOTE_ON && velocity != 7'd0) begin
        result.valid    = 1'b1;
        result.kind     = KIND_NOTE_ON;
        result.note     = first_data_next;
        result.velocity = velocity;
      end else if (status_held == STATUS_NOTE_ON || status_held == STATUS_NOTE_OFF) begin
        result.valid    = 1'b1;
        result.kind     = KIND_NOTE_OFF;
        result.note     = first_data_next;
        result.velocity = 7'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status_held    <= STATUS_RESET;
      message_length <= LEN_FULL;
      byte_position  <= POS_NONE;
      first_data     <= 7'd0;
    end else if (advance) begin
      status_held    <= status_held_next;
      message_length <= message_length_next;
      byte_position  <= byte_position_next;
      first_data     <= first_data_next;
    end
  end

endmodule

/* hw/rtl/midi_note_message_parser.sv */
// MIDI note message parser, top level.
// Path: an accepted word is held in the input register for decode, and its note
// event is then loaded into the output register.
// Throughput: one word per cycle while the decode stage advances; it advances whenever the
// output register is empty or being drained, or its word yields no event.
// Reset clears the valid flags and parser state at once; payload registers are not reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module midi_note_message_parser
  import mnp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_ready,
  input  logic [7:0] rx_byte,
  output logic       event_valid,
  input  logic       event_ready,
  output logic       event_kind,
  output logic [6:0] note_number,
  output logic [6:0] note_velocity
);

  logic        byte_valid;
  logic [7:0]  byte_data;
  logic        advance;
  logic        out_free;
  mnp_result_t result;

  // Hold the received word until decode can move it on.
  mnp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_valid),
    .rx_ready   (rx_ready),
    .rx_byte    (rx_byte),
    .advance    (advance),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  // Parser state and decode; state only moves when the word advances.
  mnp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .byte_data (byte_data),
    .result    (result)
  );

  // The output register takes a new event when empty or being drained.
  // A word that yields no event passes even while an event waits, so the
  // input side keeps flowing.
  assign out_free = !event_valid || event_ready;
  assign advance  = byte_valid && (out_free || !result.valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (out_free) begin
      event_valid <= advance && result.valid;
    end
  end

  // Load payload only with a real event; hold it while stalled.
  always_ff @(posedge clk) begin
    if (advance && result.valid) begin
      event_kind    <= result.kind;
      note_number   <= result.note;
      note_velocity <= result.velocity;
    end
  end

  // A note on always carries a velocity; a note off never does.
  `MNP_ASSERT_IMPL(a_on_has_vel, event_valid && event_kind == KIND_NOTE_ON,
                   note_velocity != 7'd0, "note on with zero velocity")
  `MNP_ASSERT_IMPL(a_off_no_vel, event_valid && event_kind == KIND_NOTE_OFF,
                   note_velocity == 7'd0, "note off with nonzero velocity")
  // A decoded event must land in the output register.
  `MNP_ASSERT_NEXT(a_event_lands, advance && result.valid, event_valid,
                   "decoded event lost")
  // A stalled word in the decode stage must not vanish.
  `MNP_ASSERT_NEXT(a_word_holds, byte_valid && !advance, byte_valid,
                   "stalled word dropped")

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for midi_note_message_parser: drives a MIDI byte stream and
// checks every note event against a predictor kept in step with the accepted words.
// Depends on mnp_pkg for status codes, lengths, positions and event kinds.
`timescale 1ns / 1ps

module tb_top;
  import mnp_pkg::*;

  typedef struct packed {
    logic       kind;
    logic [6:0] note;
    logic [6:0] velocity;
  } note_event_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       rx_valid = 1'b0;
  logic       rx_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       event_valid;
  logic       event_ready = 1'b0;
  logic       event_kind;
  logic [6:0] note_number;
  logic [6:0] note_velocity;

  midi_note_message_parser u_dut (
    .clk          (clk),
    .rst          (rst),
    .rx_valid     (rx_valid),
    .rx_ready     (rx_ready),
    .rx_byte      (rx_byte),
    .event_valid  (event_valid),
    .event_ready  (event_ready),
    .event_kind   (event_kind),
    .note_number  (note_number),
    .note_velocity(note_velocity)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Bytes still to be sent, and note events the parser owes us, oldest first.
  logic [7:0]  midi_stream[$];
  note_event_t predicted_notes[$];
  int unsigned mismatch_count = 0;

  // Shadow copy of the parser state, reset values included.
  logic [7:0] last_status = STATUS_RESET;
  logic [1:0] msg_len     = LEN_FULL;
  logic [1:0] msg_pos     = POS_NONE;
  logic [6:0] first_note  = 7'd0;

  // Advance the shadow parser by one accepted word; queue the note event it completes.
  task automatic decode_midi_word(input logic [7:0] b);
    logic [6:0]  vel;
    logic        done;
    note_event_t ev;
    vel  = 7'd0;
    done = 1'b0;
    if (b[7]) begin
      // Status word: hold it and restart the message. Only the note and
      // channel pressure codes change the length; anything else keeps it.
      if (b == STATUS_NOTE_ON || b == STATUS_NOTE_OFF) msg_len = LEN_FULL;
      else if (b == STATUS_CHAN_PRES) msg_len = LEN_SHORT;
      last_status = b;
      msg_pos     = POS_STATUS;
    end else if (msg_pos != POS_NONE) begin
      // Data word. Drop it silently while no status has been seen.
      if (msg_pos == POS_STATUS) begin
        first_note = b[6:0];
        msg_pos    = POS_FIRST;
        done       = (msg_len <= LEN_SHORT);
      end else begin
        vel  = b[6:0];
        done = 1'b1;
      end
      if (done) begin
        // Return to the first data slot so running status keeps working.
        msg_pos = POS_STATUS;
        if (last_status == STATUS_NOTE_ON && vel != 7'd0) begin
          ev.kind     = KIND_NOTE_ON;
          ev.note     = first_note;
          ev.velocity = vel;
          predicted_notes.push_back(ev);
        end else if (last_status == STATUS_NOTE_ON || last_status == STATUS_NOTE_OFF) begin
          ev.kind     = KIND_NOTE_OFF;
          ev.note     = first_note;
          ev.velocity = 7'd0;
          predicted_notes.push_back(ev);
        end
      end
    end
  endtask

  // Draw how long a side idles before its next word. Now and then start a
  // stretch of back-to-back words with no idling at all.
  function automatic int draw_wait(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet_left = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  // ---------------------------------------------------------------- driver
  bit word_taken = 1'b0;
  bit word_busy  = 1'b0;
  int gap_left   = 0;
  int tx_quiet   = 0;

  // Record acceptance at the edge and step the predictor with the word taken.
  always @(posedge clk) begin
    if (!rst && rx_valid && rx_ready) begin
      decode_midi_word(rx_byte);
      word_taken = 1'b1;
    end
  end

  // Present words at the falling edge. Hold valid and the byte until taken;
  // keep valid high across back-to-back words with a single assignment.
  always @(negedge clk) begin
    if (!rst) begin
      if (word_taken) begin
        word_taken = 1'b0;
        word_busy  = 1'b0;
        gap_left   = draw_wait(tx_quiet);
      end
      if (!word_busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (midi_stream.size() != 0) begin
          rx_byte  <= midi_stream.pop_front();
          word_busy = 1'b1;
        end
      end
      rx_valid <= word_busy;
    end
  end

  // --------------------------------------------------------------- monitor
  bit event_taken = 1'b0;
  int ready_hold  = 0;
  int ev_quiet    = 0;

  // Compare each accepted event with the oldest prediction, field by field.
  always @(posedge clk) begin
    if (!rst && event_valid && event_ready) begin
      event_taken = 1'b1;
      if (predicted_notes.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected event: expected none, actual kind %0d note %0d velocity %0d",
                 $time, event_kind, note_number, note_velocity);
      end else begin
        note_event_t exp_ev;
        exp_ev = predicted_notes.pop_front();
        if (event_kind !== exp_ev.kind) begin
          mismatch_count++;
          $display("%0t: event_kind mismatch: expected %0d, actual %0d",
                   $time, exp_ev.kind, event_kind);
        end
        if (note_number !== exp_ev.note) begin
          mismatch_count++;
          $display("%0t: note_number mismatch: expected %0d, actual %0d",
                   $time, exp_ev.note, note_number);
        end
        if (note_velocity !== exp_ev.velocity) begin
          mismatch_count++;
          $display("%0t: note_velocity mismatch: expected %0d, actual %0d",
                   $time, exp_ev.velocity, note_velocity);
        end
      end
    end
  end

  // Stall the event side for a drawn number of cycles after each event.
  always @(negedge clk) begin
    if (!rst) begin
      if (event_taken) begin
        event_taken = 1'b0;
        ready_hold  = draw_wait(ev_quiet);
      end
      if (ready_hold > 0) begin
        ready_hold--;
        event_ready <= 1'b0;
      end else begin
        event_ready <= 1'b1;
      end
    end
  end

  // -------------------------------------------------------------- stimulus
  task automatic send_word(input logic [7:0] b);
    midi_stream.push_back(b);
  endtask

  initial begin
    int         pick;
    int         msgs;
    logic [7:0] status;
    logic [6:0] data7;

    // Directed: data before any status is dropped.
    send_word(8'h00);
    send_word(8'h7F);
    // Note on at the field extremes, then running status.
    send_word(STATUS_NOTE_ON);
    send_word(8'h00);
    send_word(8'h7F);
    send_word(8'h7F);
    send_word(8'h01);
    // Note on with zero velocity reads as note off.
    send_word(8'h40);
    send_word(8'h00);
    // Explicit note off; velocity is dropped.
    send_word(STATUS_NOTE_OFF);
    send_word(8'h7F);
    send_word(8'h7F);
    // Two-word message: completes on one data word, yields nothing.
    send_word(STATUS_CHAN_PRES);
    send_word(8'h15);
    send_word(8'h16);
    // Other status keeps the short length.
    send_word(8'hF8);
    send_word(8'h22);
    // Status in the middle of a note message restarts it.
    send_word(STATUS_NOTE_ON);
    send_word(8'h3C);
    send_word(8'hFE);
    send_word(8'h3D);
    send_word(8'h50);
    // Another channel is not decoded.
    send_word(8'h91);
    send_word(8'h10);
    send_word(8'h20);
    send_word(8'hFF);

    // Random: mostly well-formed note messages with running status, laced
    // with stray status words, random bytes and dropped data words.
    while (midi_stream.size() < 720) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) status = STATUS_NOTE_ON;
      else if (pick < 70) status = STATUS_NOTE_OFF;
      else if (pick < 80) status = STATUS_CHAN_PRES;
      else status = 8'h80 | 8'($urandom_range(0, 127));
      send_word(status);
      msgs = $urandom_range(1, 4);
      for (int m = 0; m < msgs; m++) begin
        data7 = 7'($urandom_range(0, 127));
        send_word({1'b0, data7});
        if ($urandom_range(0, 24) != 0) begin
          if ($urandom_range(0, 5) == 0) data7 = 7'd0;
          else data7 = 7'($urandom_range(0, 127));
          send_word({1'b0, data7});
        end
        case ($urandom_range(0, 19))
          0: send_word(8'h80 | 8'($urandom_range(0, 127)));
          1: send_word(8'($urandom_range(0, 255)));
          default: ;
        endcase
      end
    end

    // Reset once, then release it at a falling edge.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Drain: every word accepted, every predicted event received, then
    // give the output stage time to show any stray event.
    while (midi_stream.size() != 0 || word_busy) @(posedge clk);
    while (predicted_notes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/mnp_pkg.sv
hw/rtl/mnp_in_reg.sv
hw/rtl/mnp_core.sv
hw/rtl/midi_note_message_parser.sv
tb/tb_top.sv
